// ===== src/pfla_pkg.sv =====
// Shared types and constants of the page free-list allocator.
`default_nettype none
package pfla_pkg;

    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = 10;              // page number width
    localparam int CNT_W     = 11;              // page count / link width
    localparam int IDX_W     = 12;              // signed request index width
    localparam int ENTRY_W   = CNT_W + 1;       // {used, link}

    localparam logic [CNT_W-1:0] LIST_END  = CNT_W'(MAX_PAGES);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_PAGES);

    typedef enum logic [2:0] {
        REQ_ALLOC   = 3'd0,
        REQ_DISPOSE = 3'd1,
        REQ_CHECK   = 3'd2,
        REQ_NEXT    = 3'd3,
        REQ_PREV    = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FREE    = 3'd2,
        ST_EOF     = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // Result handed from the sequencer to the output stage.
    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [PAGE_W-1:0] page;
    } t_res_bus;

endpackage
`default_nettype wire

// ===== src/pfla_req_if.sv =====
// Request channel: valid/ready with request type and page index.
`default_nettype none
interface pfla_req_if
    import pfla_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [2:0]              req_type;
    logic signed [IDX_W-1:0] page_index;

    modport source (output valid, output req_type, output page_index, input ready);
    modport sink   (input valid, input req_type, input page_index, output ready);
endinterface
`default_nettype wire

// ===== src/pfla_rsp_if.sv =====
// Response channel: valid/ready with status and page number.
`default_nettype none
interface pfla_rsp_if
    import pfla_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output status, output page_number, input ready);
    modport sink   (input valid, input status, input page_number, output ready);
endinterface
`default_nettype wire

// ===== src/pfla_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module pfla_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/pfla_ctrl.sv =====
// Request sequencer: range checks, table access and the page scan loop.
`default_nettype none
module pfla_ctrl
    import pfla_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic [2:0]              i_req_type,
    input  wire logic signed [IDX_W-1:0] i_page_index,
    output logic                         o_ready,
    output t_res_bus                     o_res,
    input  wire logic                    i_res_taken,
    output logic                         o_ram_we,
    output logic [PAGE_W-1:0]            o_ram_addr,
    output logic [ENTRY_W-1:0]           o_ram_wdata,
    input  wire logic [ENTRY_W-1:0]      i_ram_rdata
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [2:0]              r_req;
    logic signed [IDX_W-1:0] r_idx;
    logic [PAGE_W-1:0]       r_ptr, n_ptr;
    logic [CNT_W-1:0]        r_head, n_head;
    logic [CNT_W-1:0]        r_count, n_count;
    t_status                 r_status, n_status;
    logic [PAGE_W-1:0]       r_page, n_page;

    logic signed [IDX_W-1:0] w_cnt_s;
    logic signed [IDX_W-1:0] w_idx_inc;
    logic signed [IDX_W-1:0] w_idx_dec;
    logic [CNT_W-1:0]        w_step;
    logic                    w_used;
    logic [CNT_W-1:0]        w_link;

    assign w_cnt_s   = $signed({1'b0, r_count});
    assign w_idx_inc = r_idx + 12'sd1;
    assign w_idx_dec = r_idx - 12'sd1;
    assign w_used    = i_ram_rdata[ENTRY_W-1];
    assign w_link    = i_ram_rdata[CNT_W-1:0];

    // shared step unit: one page up or down per scan cycle
    assign w_step = (t_req'(r_req) == REQ_PREV) ? ({1'b0, r_ptr} - 11'd1)
                                                 : ({1'b0, r_ptr} + 11'd1);

    assign o_ready      = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.page   = r_page;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_head      = r_head;
        n_count     = r_count;
        n_status    = r_status;
        n_page      = r_page;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_ptr;
        o_ram_wdata = {1'b1, w_link};

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_status = ST_INVALID;
                n_page   = '0;
                n_state  = S_DONE;
                case (t_req'(r_req))
                    REQ_ALLOC: begin
                        if (r_head != LIST_END) begin
                            n_ptr      = r_head[PAGE_W-1:0];
                            o_ram_addr = r_head[PAGE_W-1:0];
                            n_state    = S_EVAL;
                        end else if (r_count == COUNT_MAX) begin
                            n_status = ST_FULL;
                        end else begin
                            // list empty: grow the file by one page
                            o_ram_we    = 1'b1;
                            o_ram_addr  = r_count[PAGE_W-1:0];
                            o_ram_wdata = {1'b1, LIST_END};
                            n_count     = r_count + 11'd1;
                            n_status    = ST_OK;
                            n_page      = r_count[PAGE_W-1:0];
                        end
                    end
                    REQ_DISPOSE, REQ_CHECK: begin
                        if (r_idx >= 12'sd0 && r_idx < w_cnt_s) begin
                            n_ptr      = r_idx[PAGE_W-1:0];
                            o_ram_addr = r_idx[PAGE_W-1:0];
                            n_state    = S_EVAL;
                        end
                    end
                    REQ_NEXT: begin
                        if (r_idx >= -12'sd1 && r_idx < w_cnt_s) begin
                            if (w_idx_inc >= w_cnt_s) begin
                                n_status = ST_EOF;
                            end else begin
                                n_ptr      = w_idx_inc[PAGE_W-1:0];
                                o_ram_addr = w_idx_inc[PAGE_W-1:0];
                                n_state    = S_EVAL;
                            end
                        end
                    end
                    REQ_PREV: begin
                        if (r_idx > 12'sd0 && r_idx <= w_cnt_s) begin
                            n_ptr      = w_idx_dec[PAGE_W-1:0];
                            o_ram_addr = w_idx_dec[PAGE_W-1:0];
                            n_state    = S_EVAL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EVAL: begin
                // table entry of r_ptr is on i_ram_rdata
                n_state = S_DONE;
                case (t_req'(r_req))
                    REQ_ALLOC: begin
                        n_head      = w_link;
                        o_ram_we    = 1'b1;
                        o_ram_wdata = {1'b1, w_link};
                        n_status    = ST_OK;
                        n_page      = r_ptr;
                    end
                    REQ_DISPOSE: begin
                        if (!w_used) begin
                            n_status = ST_FREE;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_wdata = {1'b0, r_head};
                            n_head      = {1'b0, r_ptr};
                            n_status    = ST_OK;
                        end
                    end
                    REQ_CHECK: begin
                        if (w_used) begin
                            n_status = ST_OK;
                            n_page   = r_ptr;
                        end
                    end
                    REQ_NEXT: begin
                        if (w_used) begin
                            n_status = ST_OK;
                            n_page   = r_ptr;
                        end else if (w_step >= r_count) begin
                            n_status = ST_EOF;
                        end else begin
                            n_ptr      = w_step[PAGE_W-1:0];
                            o_ram_addr = w_step[PAGE_W-1:0];
                            n_state    = S_EVAL;
                        end
                    end
                    REQ_PREV: begin
                        if (w_used) begin
                            n_status = ST_OK;
                            n_page   = r_ptr;
                        end else if (r_ptr == '0) begin
                            n_status = ST_EOF;
                        end else begin
                            n_ptr      = w_step[PAGE_W-1:0];
                            o_ram_addr = w_step[PAGE_W-1:0];
                            n_state    = S_EVAL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= LIST_END;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_req <= i_req_type;
            r_idx <= i_page_index;
        end
        r_ptr    <= n_ptr;
        r_status <= n_status;
        r_page   <= n_page;
    end
endmodule
`default_nettype wire

// ===== src/page_free_list_allocator_top.sv =====
// Top level of the page free-list allocator: sequencer, page table RAM, output stage.
// Path: allocate from the page count end, or any rejected request, goes from S_START
//   to S_DONE and then the output register; table lookups go S_START, S_EVAL, S_DONE;
//   a next/prev scan loops in S_EVAL, one page per cycle, to a used page or the end.
// Requests: one at a time; a new request is taken while a result waits in the output
//   stage.
// Reset: free-list head to list end, page count to zero; the table is not cleared.
`default_nettype none
module page_free_list_allocator_top
    import pfla_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pfla_req_if.sink    i_req,
    pfla_rsp_if.source  o_rsp
);
    t_res_bus               w_res;
    logic                   w_res_taken;
    logic                   w_ram_we;
    logic [PAGE_W-1:0]      w_ram_addr;
    logic [ENTRY_W-1:0]     w_ram_wdata;
    logic [ENTRY_W-1:0]     w_ram_rdata;

    logic                   r_out_valid;
    logic [2:0]             r_out_status;
    logic [PAGE_W-1:0]      r_out_page;

    // Sequencer: owns free-list head, page count and the scan pointer.
    pfla_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .i_req_type   (i_req.req_type),
        .i_page_index (i_req.page_index),
        .o_ready      (i_req.ready),
        .o_res        (w_res),
        .i_res_taken  (w_res_taken),
        .o_ram_we     (w_ram_we),
        .o_ram_addr   (w_ram_addr),
        .o_ram_wdata  (w_ram_wdata),
        .i_ram_rdata  (w_ram_rdata)
    );

    // Page table: each entry is {used, next free link}.
    pfla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PAGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Output register: loads when empty or being drained this cycle.
    assign w_res_taken = w_res.valid && (!r_out_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_taken) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_taken) begin
            r_out_status <= w_res.status;
            r_out_page   <= w_res.page;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.page_number = r_out_page;
endmodule
`default_nettype wire
